[design/prp_pkg.sv]
// ---------------------------------------------------------------------------
// prp_pkg
// Shared types and register codes for the pairwise row product block.
// ---------------------------------------------------------------------------
`default_nettype none

package prp_pkg;

  // register index codes, taken from paddr[3:2]
  localparam logic [1:0] REG_ROW_LEN = 2'd0;
  localparam logic [1:0] REG_ROWS_Y  = 2'd1;
  localparam logic [1:0] REG_ROWS_X  = 2'd2;

  localparam int unsigned RX_MAX = 256;

  // effective (clamped) configuration
  typedef struct packed {
    logic [6:0] len;
    logic [4:0] ry;
    logic [8:0] rx;
  } cfg_t;

endpackage

`default_nettype wire

[design/prp_regs.sv]
// ---------------------------------------------------------------------------
// prp_regs
// Configuration registers on the APB-style port, with clamped values out.
// ---------------------------------------------------------------------------
`default_nettype none

module prp_regs #(
  parameter int unsigned LEN_HI = 64,
  parameter int unsigned RY_HI  = 16
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [3:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic [31:0]       prdata,
  output prp_pkg::cfg_t     cfg
);

  logic [6:0] row_len;
  logic [4:0] rows_y;
  logic [8:0] rows_x;
  logic       wr_en;

  assign wr_en = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_len <= 7'd64;
      rows_y  <= 5'd16;
      rows_x  <= 9'd16;
    end else if (wr_en) begin
      unique case (paddr[3:2])
        prp_pkg::REG_ROW_LEN: row_len <= pwdata[6:0];
        prp_pkg::REG_ROWS_Y:  rows_y  <= pwdata[4:0];
        prp_pkg::REG_ROWS_X:  rows_x  <= pwdata[8:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      prp_pkg::REG_ROW_LEN: prdata = {25'd0, row_len};
      prp_pkg::REG_ROWS_Y:  prdata = {27'd0, rows_y};
      prp_pkg::REG_ROWS_X:  prdata = {23'd0, rows_x};
      default:              prdata = 32'd0;
    endcase
  end

  // zero acts as one, anything above the limit acts as the limit
  always_comb begin
    if (row_len == 7'd0)            cfg.len = 7'd1;
    else if (row_len > 7'(LEN_HI))  cfg.len = 7'(LEN_HI);
    else                            cfg.len = row_len;

    if (rows_y == 5'd0)             cfg.ry = 5'd1;
    else if (rows_y > 5'(RY_HI))    cfg.ry = 5'(RY_HI);
    else                            cfg.ry = rows_y;

    if (rows_x == 9'd0)                          cfg.rx = 9'd1;
    else if (rows_x > 9'(prp_pkg::RX_MAX))       cfg.rx = 9'(prp_pkg::RX_MAX);
    else                                         cfg.rx = rows_x;
  end

endmodule

`default_nettype wire

[design/pairwise_row_product.sv]
// A y element is written into the store in the cycle it is accepted; y
// elements go at one per cycle while no x element is still being expanded.
// An x element yields rows_y results through item, read and output registers,
// one per cycle while out_ready stays high. The next x element is taken as
// the last row read of the one before issues, set by the single read port.
// Reset clears counters, phase and pipeline valids; the y store is not cleared.
// ---------------------------------------------------------------------------
// pairwise_row_product
// Stores y rows per sample, then multiplies each streamed x element by the
// matching column of every stored y row.
// ---------------------------------------------------------------------------
`default_nettype none

module pairwise_row_product #(
  parameter int unsigned MAX_ROWS_Y  = 16,
  parameter int unsigned MAX_ROW_LEN = 64
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [3:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [15:0] sample_value,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [31:0]      product,
  output logic [11:0]             pair_index,
  output logic [5:0]              column,
  output logic                    run_last,
  output logic                    sample_last
);

  localparam int unsigned DEPTH  = MAX_ROWS_Y * MAX_ROW_LEN;
  localparam int unsigned AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned LEN_HI = (MAX_ROW_LEN < 64) ? MAX_ROW_LEN : 64;
  localparam int unsigned RY_HI  = (MAX_ROWS_Y < 16) ? MAX_ROWS_Y : 16;

  prp_pkg::cfg_t cfg;

  prp_regs #(.LEN_HI(LEN_HI), .RY_HI(RY_HI)) u_regs (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .cfg(cfg)
  );

  assign pready = 1'b1;

  // phase and position counters
  logic       loading_y;
  logic [7:0] row_count;
  logic [5:0] col_count;
  logic       last_col;
  logic       last_row;
  logic       accept;

  // x item being expanded
  logic              busy;
  logic [3:0]        k;
  logic signed [15:0] item_x;
  logic [5:0]        item_col;
  logic [11:0]       item_base;
  logic              item_last;
  logic              issue;
  logic              issue_last;

  // read stage
  logic              rd_valid;
  logic signed [15:0] rd_y;
  logic signed [15:0] rd_x;
  logic [11:0]       rd_pair;
  logic [5:0]        rd_col;
  logic              rd_run_last;
  logic              rd_sample_last;
  logic              out_take;
  logic signed [31:0] product_next;

  logic signed [15:0] y_mem [DEPTH];
  logic [31:0]       wr_addr_full;
  logic [31:0]       rd_addr_full;
  logic [AW-1:0]     wr_addr;
  logic [AW-1:0]     rd_addr;

  assign last_col = ({1'b0, col_count} + 7'd1) >= cfg.len;
  assign last_row = loading_y ? (({1'b0, row_count} + 9'd1) >= {4'd0, cfg.ry})
                              : (({1'b0, row_count} + 9'd1) >= cfg.rx);

  assign out_take   = rd_valid & (~out_valid | out_ready);
  assign issue      = busy & (~rd_valid | out_take);
  assign issue_last = ({1'b0, k} + 5'd1) == cfg.ry;
  assign in_ready   = ~busy | (issue & issue_last);
  assign accept     = in_valid & in_ready;

  assign wr_addr_full = 32'(row_count) * 32'(MAX_ROW_LEN) + 32'(col_count);
  assign rd_addr_full = 32'(k) * 32'(MAX_ROW_LEN) + 32'(item_col);
  assign wr_addr      = wr_addr_full[AW-1:0];
  assign rd_addr      = rd_addr_full[AW-1:0];

  // y store: one write port, one registered read port, read-first
  always_ff @(posedge clk) begin
    if (accept && loading_y) begin
      y_mem[wr_addr] <= sample_value;
    end
    if (issue) begin
      rd_y <= y_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      loading_y <= 1'b1;
      row_count <= 8'd0;
      col_count <= 6'd0;
    end else if (accept) begin
      if (last_col) begin
        col_count <= 6'd0;
        if (last_row) begin
          row_count <= 8'd0;
          loading_y <= ~loading_y;
        end else begin
          row_count <= row_count + 8'd1;
        end
      end else begin
        col_count <= col_count + 6'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      k    <= 4'd0;
    end else if (accept && !loading_y) begin
      busy <= 1'b1;
      k    <= 4'd0;
    end else if (issue) begin
      if (issue_last) begin
        busy <= 1'b0;
      end
      k <= k + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !loading_y) begin
      item_x    <= sample_value;
      item_col  <= col_count;
      item_base <= 12'(13'(row_count) * 13'(cfg.ry));
      item_last <= last_col & last_row;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else if (issue) begin
      rd_valid <= 1'b1;
    end else if (out_take) begin
      rd_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      rd_x           <= item_x;
      rd_pair        <= item_base + 12'(k);
      rd_col         <= item_col;
      rd_run_last    <= issue_last;
      rd_sample_last <= issue_last & item_last;
    end
  end

  assign product_next = rd_x * rd_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_take) begin
      product     <= product_next;
      pair_index  <= rd_pair;
      column      <= rd_col;
      run_last    <= rd_run_last;
      sample_last <= rd_sample_last;
    end
  end

  a_rd_hold: assert property (@(posedge clk) disable iff (rst)
    rd_valid && !out_take |=> rd_valid)
    else $error("read stage dropped a pending result");

  a_k_range: assert property (@(posedge clk) disable iff (rst)
    issue |-> ({1'b0, k} < cfg.ry))
    else $error("read issued beyond the stored rows");

  a_y_no_work: assert property (@(posedge clk) disable iff (rst)
    accept && loading_y |=> !busy)
    else $error("y element started result work");

  a_run_end: assert property (@(posedge clk) disable iff (rst)
    issue && issue_last && !(accept && !loading_y) |=> !busy)
    else $error("sequencer kept running after the last stored row");

  a_sample_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && sample_last |-> run_last)
    else $error("sample end flagged off a run end");

endmodule

`default_nettype wire
